>>> hdl/apg_pkg.sv
package apg_pkg;

	localparam int PORT_COUNT = 26;
	localparam int PORT_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;

	localparam logic [15:0] RATE_HZ = 16'd48000;
	localparam logic [3:0] GRAIN_K_MIN = 4'd1;
	localparam logic [3:0] GRAIN_K_MAX = 4'd8;
	localparam logic [7:0] MAX_CHANNELS = 8'd8;
	localparam logic [15:0] WAIT_MAX = 16'hFFFF;

	typedef enum logic [2:0] {
		ACT_IDLE      = 3'd0,
		ACT_BAD_SHAPE = 3'd1,
		ACT_MISMATCH  = 3'd2,
		ACT_NO_AREA   = 3'd3,
		ACT_NOT_DUE   = 3'd4,
		ACT_PLAY      = 3'd5,
		ACT_DRAIN     = 3'd6
	} action_t;

	// Outcome of the front checks; only CLS_TIMED needs per-port state.
	typedef enum logic [2:0] {
		CLS_IDLE,
		CLS_BAD_SHAPE,
		CLS_MISMATCH,
		CLS_NO_AREA,
		CLS_TIMED
	} class_t;

	localparam logic [1:0] TYPE_INT16 = 2'd0;
	localparam logic [1:0] TYPE_INT32 = 2'd2;

	typedef struct packed {
		class_t      cls;
		logic [4:0]  port;
		logic [3:0]  channels;
		logic [16:0] copy_bytes;
		logic [5:0]  frame_bytes;
		logic [1:0]  stype;
		logic [3:0]  grain_k;
		logic [47:0] now_us;
	} req_t;

	typedef struct packed {
		logic valid;
		logic full;
	} q_status_t;

	typedef struct packed {
		logic        done;
		action_t     action;
		logic        clear_and_grant;
		logic        reopen_sink;
		logic [3:0]  channels;
		logic [16:0] copy_bytes;
		logic [15:0] wait_us;
	} res_t;

	// Pacing period in microseconds for a grain of k*256 frames at 48 kHz, rounded down.
	function automatic logic [15:0] period_us(input logic [3:0] k);
		logic [15:0] p;
		case (k)
			4'd1: p = 16'd5333;
			4'd2: p = 16'd10666;
			4'd3: p = 16'd16000;
			4'd4: p = 16'd21333;
			4'd5: p = 16'd26666;
			4'd6: p = 16'd32000;
			4'd7: p = 16'd37333;
			4'd8: p = 16'd42666;
			default: p = 16'd0;
		endcase
		return p;
	endfunction

endpackage

>>> hdl/audio_port_paced_grant_unit.sv
// Channel   Direction  Handshake                    Contents
// request   in         start high while busy low    port, token, shape, index, area, time
// result    out        done high for one cycle      action, grant, reopen, channels, size, wait
//
// A request is classified in the cycle it is taken and written into a two-entry queue.
// The back end drains one queue entry per cycle; a request passes through its queue slot
// and the result register before reaching the output. One request per cycle is sustained,
// a rate set by the single read-modify-write of the per-port schedule in the back end.
// Reset clears the queue, the output strobe and every port's schedule and last shape.
// The receiver cannot stall; busy rises only if the queue is full.
module audio_port_paced_grant_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [4:0]  port,
	input  logic        token_set,
	input  logic [7:0]  bytes_per_frame,
	input  logic [2:0]  sample_type,
	input  logic [15:0] sample_rate,
	input  logic [11:0] grain,
	input  logic [7:0]  declared_index,
	input  logic        area_mapped,
	input  logic [16:0] area_size,
	input  logic [47:0] now_us,
	output logic        done,
	output logic [2:0]  action,
	output logic        clear_and_grant,
	output logic        reopen_sink,
	output logic [3:0]  channels,
	output logic [16:0] copy_bytes,
	output logic [15:0] wait_us
);

	apg_pkg::req_t      front_req;
	apg_pkg::req_t      head;
	apg_pkg::q_status_t q_status;
	apg_pkg::res_t      res;
	logic               accept;

	// A request is taken whenever the queue has room.
	assign busy = q_status.full;
	assign accept = start && !busy;

	// The front end checks shape, index and area without any per-port state.
	apg_front u_front (
		.port            (port),
		.token_set       (token_set),
		.bytes_per_frame (bytes_per_frame),
		.sample_type     (sample_type),
		.sample_rate     (sample_rate),
		.grain           (grain),
		.declared_index  (declared_index),
		.area_mapped     (area_mapped),
		.area_size       (area_size),
		.now_us          (now_us),
		.req             (front_req)
	);

	// The queue decouples the classification from the schedule update.
	apg_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_req (front_req),
		.pop      (1'b1),
		.head     (head),
		.status   (q_status)
	);

	// The back end owns the per-port pacing state and registers each result.
	apg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_status.valid),
		.head       (head),
		.res        (res)
	);

	assign done = res.done;
	assign action = res.action;
	assign clear_and_grant = res.clear_and_grant;
	assign reopen_sink = res.reopen_sink;
	assign channels = res.channels;
	assign copy_bytes = res.copy_bytes;
	assign wait_us = res.wait_us;

endmodule

>>> hdl/apg_front.sv
module apg_front (
	input  logic [4:0]       port,
	input  logic             token_set,
	input  logic [7:0]       bytes_per_frame,
	input  logic [2:0]       sample_type,
	input  logic [15:0]      sample_rate,
	input  logic [11:0]      grain,
	input  logic [7:0]       declared_index,
	input  logic             area_mapped,
	input  logic [16:0]      area_size,
	input  logic [47:0]      now_us,
	output apg_pkg::req_t    req
);

	logic [7:0]  ch;
	logic        bpf_ok;
	logic        grain_ok;
	logic        shape_ok;
	logic [19:0] need;
	logic        in_range;

	always_comb begin
		if (sample_type == {1'b0, apg_pkg::TYPE_INT16}) begin
			ch = {1'b0, bytes_per_frame[7:1]};
			bpf_ok = (bytes_per_frame[0] == 1'b0);
		end else begin
			ch = {2'b00, bytes_per_frame[7:2]};
			bpf_ok = (bytes_per_frame[1:0] == 2'b00);
		end
		bpf_ok = bpf_ok && (ch != 8'd0) && (ch <= apg_pkg::MAX_CHANNELS);
		grain_ok = (grain[7:0] == 8'd0) && (grain[11:8] >= apg_pkg::GRAIN_K_MIN)
			&& (grain[11:8] <= apg_pkg::GRAIN_K_MAX);
		shape_ok = (sample_rate == apg_pkg::RATE_HZ) && grain_ok
			&& (sample_type <= {1'b0, apg_pkg::TYPE_INT32}) && bpf_ok;
		need = 20'(grain) * 20'(bytes_per_frame);
		in_range = (int'(port) < apg_pkg::PORT_COUNT);
	end

	always_comb begin
		req = '0;
		req.port = port;
		req.frame_bytes = bytes_per_frame[5:0];
		req.stype = sample_type[1:0];
		req.grain_k = grain[11:8];
		req.now_us = now_us;
		if (!in_range || !token_set) begin
			req.cls = apg_pkg::CLS_IDLE;
		end else if (!shape_ok) begin
			req.cls = apg_pkg::CLS_BAD_SHAPE;
		end else begin
			req.channels = ch[3:0];
			req.copy_bytes = need[16:0];
			if (declared_index != {3'b000, port}) begin
				req.cls = apg_pkg::CLS_MISMATCH;
			end else if (!area_mapped || ({3'b000, area_size} < need)) begin
				req.cls = apg_pkg::CLS_NO_AREA;
			end else begin
				req.cls = apg_pkg::CLS_TIMED;
			end
		end
	end

endmodule

>>> hdl/apg_queue.sv
module apg_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  apg_pkg::req_t        push_req,
	input  logic                 pop,
	output apg_pkg::req_t        head,
	output apg_pkg::q_status_t   status
);

	apg_pkg::req_t slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_pop;

	assign do_pop = pop && (count_q != 2'd0);
	assign head = slot_q[rd_ptr_q];
	assign status.valid = (count_q != 2'd0);
	assign status.full = (count_q == 2'd2);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, do_pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> hdl/apg_back.sv
module apg_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  apg_pkg::req_t        head,
	output apg_pkg::res_t        res
);

	logic [47:0] next_due_q   [apg_pkg::PORT_COUNT];
	logic        known_q      [apg_pkg::PORT_COUNT];
	logic [5:0]  frame_q      [apg_pkg::PORT_COUNT];
	logic [1:0]  type_q       [apg_pkg::PORT_COUNT];
	logic [3:0]  chan_q       [apg_pkg::PORT_COUNT];

	apg_pkg::res_t res_d;
	apg_pkg::res_t res_q;

	logic [apg_pkg::PORT_W-1:0] idx;
	logic [47:0] nd;
	logic        sched;
	logic [47:0] diff;
	logic [47:0] base;
	logic [48:0] sum;
	logic [47:0] nn;
	logic        wr_en;

	assign idx = head.port[apg_pkg::PORT_W-1:0];
	assign res = res_q;

	always_comb begin
		res_d = '0;
		wr_en = 1'b0;
		nd = next_due_q[idx];
		sched = (nd != 48'd0);
		diff = nd - head.now_us;
		base = sched ? nd : head.now_us;
		sum = {1'b0, base} + {33'd0, apg_pkg::period_us(head.grain_k)};
		nn = (sum[47:0] < head.now_us) ? head.now_us : sum[47:0];
		if (head_valid) begin
			res_d.done = 1'b1;
			res_d.channels = head.channels;
			res_d.copy_bytes = head.copy_bytes;
			case (head.cls)
				apg_pkg::CLS_IDLE: res_d.action = apg_pkg::ACT_IDLE;
				apg_pkg::CLS_BAD_SHAPE: res_d.action = apg_pkg::ACT_BAD_SHAPE;
				apg_pkg::CLS_MISMATCH: res_d.action = apg_pkg::ACT_MISMATCH;
				apg_pkg::CLS_NO_AREA: res_d.action = apg_pkg::ACT_NO_AREA;
				apg_pkg::CLS_TIMED: begin
					if (sched && (head.now_us < nd)) begin
						res_d.action = apg_pkg::ACT_NOT_DUE;
						res_d.wait_us = (diff[47:16] != 32'd0) ? apg_pkg::WAIT_MAX : diff[15:0];
					end else begin
						wr_en = 1'b1;
						res_d.action = (head.stype == apg_pkg::TYPE_INT32) ?
							apg_pkg::ACT_DRAIN : apg_pkg::ACT_PLAY;
						res_d.clear_and_grant = 1'b1;
						res_d.reopen_sink = !known_q[idx] || (frame_q[idx] != head.frame_bytes)
							|| (type_q[idx] != head.stype) || (chan_q[idx] != head.channels);
					end
				end
				default: res_d.action = apg_pkg::ACT_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < apg_pkg::PORT_COUNT; i++) begin
				next_due_q[i] <= '0;
				known_q[i] <= 1'b0;
				frame_q[i] <= '0;
				type_q[i] <= '0;
				chan_q[i] <= '0;
			end
			res_q <= '0;
		end else begin
			if (wr_en) begin
				next_due_q[idx] <= nn;
				known_q[idx] <= 1'b1;
				frame_q[idx] <= head.frame_bytes;
				type_q[idx] <= head.stype;
				chan_q[idx] <= head.channels;
			end
			res_q <= res_d;
		end
	end

endmodule
